// ===== rtl/core/segi_pkg.sv =====
// ---------------------------------------------------------------------------
// segi_pkg
// Shared widths, outcome codes and pipeline payload types for the segment
// intersection block.
// ---------------------------------------------------------------------------
package segi_pkg;

  localparam int COORD_W = 29;            // input / output coordinate width
  localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;    // product of two differences
  localparam int DEN_W   = PROD_W + 1;    // den, tn, un
  localparam int Q_W     = DIFF_W;        // quotient bits, one per cell
  localparam int NUM_W   = DEN_W + Q_W;   // dividend |tn|*|diff|
  localparam int LO_W    = 31;            // low slice of |tn| for the split multiply
  localparam int HI_W    = DEN_W - LO_W;  // high slice of |tn|
  localparam int LIMIT_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 2;
  localparam int NUM_CELLS = Q_W;

  localparam logic [ADDR_W-1:0] REG_PARALLEL_LIMIT = 2'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_OUTSIDE  = 2'd2
  } outcome_e;

  // one coordinate's division in flight
  typedef struct packed {
    logic [DEN_W-1:0]          rem;
    logic [Q_W-1:0]            num_lo;
    logic [Q_W-1:0]            quo;
    logic                      neg;
    logic signed [COORD_W-1:0] base;
  } lane_t;

  typedef struct packed {
    lane_t            x;
    lane_t            y;
    logic [DEN_W-1:0] den;
    outcome_e         outcome;
  } divw_t;

endpackage

// ===== rtl/core/segi_front.sv =====
// ---------------------------------------------------------------------------
// segi_front
// Six stage front end: differences, products, cross terms, classification,
// split multiply of |tn| by the segment span and dividend assembly.
// ---------------------------------------------------------------------------
module segi_front import segi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] a_start_x_i,
  input  logic signed [COORD_W-1:0] a_start_y_i,
  input  logic signed [COORD_W-1:0] a_end_x_i,
  input  logic signed [COORD_W-1:0] a_end_y_i,
  input  logic signed [COORD_W-1:0] b_start_x_i,
  input  logic signed [COORD_W-1:0] b_start_y_i,
  input  logic signed [COORD_W-1:0] b_end_x_i,
  input  logic signed [COORD_W-1:0] b_end_y_i,
  input  logic [LIMIT_W-1:0]        limit_i,
  output logic                      valid_o,
  output divw_t                     data_o,
  input  logic                      stall_i
);

  logic [6:1] v_q;
  logic [6:1] adv;

  assign adv[6] = !v_q[6] || !stall_i;
  for (genvar k = 1; k < 6; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign in_stall_o = !adv[1];
  assign valid_o    = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: differences
  logic signed [DIFF_W-1:0]  dxa_q, dya_q, dxb_q, dyb_q, dx13_q, dy13_q;
  logic signed [COORD_W-1:0] x1_q1, y1_q1;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      dxa_q  <= DIFF_W'(a_start_x_i) - DIFF_W'(a_end_x_i);
      dya_q  <= DIFF_W'(a_start_y_i) - DIFF_W'(a_end_y_i);
      dxb_q  <= DIFF_W'(b_start_x_i) - DIFF_W'(b_end_x_i);
      dyb_q  <= DIFF_W'(b_start_y_i) - DIFF_W'(b_end_y_i);
      dx13_q <= DIFF_W'(a_start_x_i) - DIFF_W'(b_start_x_i);
      dy13_q <= DIFF_W'(a_start_y_i) - DIFF_W'(b_start_y_i);
      x1_q1  <= a_start_x_i;
      y1_q1  <= a_start_y_i;
    end
  end

  // stage 2: six products
  logic signed [PROD_W-1:0]  pda_q, pdb_q, pta_q, ptb_q, pua_q, pub_q;
  logic signed [DIFF_W-1:0]  dxa_q2, dya_q2;
  logic signed [COORD_W-1:0] x1_q2, y1_q2;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      pda_q  <= dxa_q * dyb_q;
      pdb_q  <= dya_q * dxb_q;
      pta_q  <= dx13_q * dyb_q;
      ptb_q  <= dy13_q * dxb_q;
      pua_q  <= dya_q * dx13_q;
      pub_q  <= dxa_q * dy13_q;
      dxa_q2 <= dxa_q;
      dya_q2 <= dya_q;
      x1_q2  <= x1_q1;
      y1_q2  <= y1_q1;
    end
  end

  // stage 3: den, tn, un
  logic signed [DEN_W-1:0]   den_q, tn_q, un_q;
  logic signed [DIFF_W-1:0]  dxa_q3, dya_q3;
  logic signed [COORD_W-1:0] x1_q3, y1_q3;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      den_q  <= DEN_W'(pda_q) - DEN_W'(pdb_q);
      tn_q   <= DEN_W'(pta_q) - DEN_W'(ptb_q);
      un_q   <= DEN_W'(pua_q) - DEN_W'(pub_q);
      dxa_q3 <= dxa_q2;
      dya_q3 <= dya_q2;
      x1_q3  <= x1_q2;
      y1_q3  <= y1_q2;
    end
  end

  // stage 4: classification and magnitudes
  logic [DEN_W-1:0]  den_mag_d, tn_mag_d;
  logic [DIFF_W-1:0] dx_mag_d, dy_mag_d;
  logic              t_ok, u_ok;
  outcome_e          outcome_d;

  always_comb begin
    den_mag_d = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
    tn_mag_d  = tn_q[DEN_W-1]  ? DEN_W'(-tn_q)  : DEN_W'(tn_q);
    dx_mag_d  = dxa_q3[DIFF_W-1] ? DIFF_W'(-dxa_q3) : DIFF_W'(dxa_q3);
    dy_mag_d  = dya_q3[DIFF_W-1] ? DIFF_W'(-dya_q3) : DIFF_W'(dya_q3);
    if (den_q > 0) begin
      t_ok = (tn_q >= 0) && (tn_q <= den_q);
      u_ok = (un_q >= 0) && (un_q <= den_q);
    end else begin
      t_ok = (tn_q <= 0) && (tn_q >= den_q);
      u_ok = (un_q <= 0) && (un_q >= den_q);
    end
    if (den_q == '0 || den_mag_d < DEN_W'(limit_i)) begin
      outcome_d = OUT_PARALLEL;
    end else if (!t_ok || !u_ok) begin
      outcome_d = OUT_OUTSIDE;
    end else begin
      outcome_d = OUT_HIT;
    end
  end

  logic [DEN_W-1:0]          den_mag_q4, tn_mag_q;
  logic [DIFF_W-1:0]         dx_mag_q, dy_mag_q;
  logic                      neg_x_q4, neg_y_q4;
  outcome_e                  outcome_q4;
  logic signed [COORD_W-1:0] x1_q4, y1_q4;

  // span is end - start = -dxa, negative when dxa is positive
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      den_mag_q4 <= den_mag_d;
      tn_mag_q   <= tn_mag_d;
      dx_mag_q   <= dx_mag_d;
      dy_mag_q   <= dy_mag_d;
      neg_x_q4   <= tn_q[DEN_W-1] ^ den_q[DEN_W-1] ^ (dxa_q3 > 0);
      neg_y_q4   <= tn_q[DEN_W-1] ^ den_q[DEN_W-1] ^ (dya_q3 > 0);
      outcome_q4 <= outcome_d;
      x1_q4      <= x1_q3;
      y1_q4      <= y1_q3;
    end
  end

  // stage 5: |tn| * |span| as two partial products per coordinate
  logic [LO_W+DIFF_W-1:0]    plx_q, ply_q;
  logic [HI_W+DIFF_W-1:0]    phx_q, phy_q;
  logic [DEN_W-1:0]          den_mag_q5;
  logic                      neg_x_q5, neg_y_q5;
  outcome_e                  outcome_q5;
  logic signed [COORD_W-1:0] x1_q5, y1_q5;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      plx_q      <= (LO_W+DIFF_W)'(tn_mag_q[LO_W-1:0]) * (LO_W+DIFF_W)'(dx_mag_q);
      ply_q      <= (LO_W+DIFF_W)'(tn_mag_q[LO_W-1:0]) * (LO_W+DIFF_W)'(dy_mag_q);
      phx_q      <= (HI_W+DIFF_W)'(tn_mag_q[DEN_W-1:LO_W]) * (HI_W+DIFF_W)'(dx_mag_q);
      phy_q      <= (HI_W+DIFF_W)'(tn_mag_q[DEN_W-1:LO_W]) * (HI_W+DIFF_W)'(dy_mag_q);
      den_mag_q5 <= den_mag_q4;
      neg_x_q5   <= neg_x_q4;
      neg_y_q5   <= neg_y_q4;
      outcome_q5 <= outcome_q4;
      x1_q5      <= x1_q4;
      y1_q5      <= y1_q4;
    end
  end

  // stage 6: dividend assembly, top bits preload the remainder
  logic [NUM_W-1:0] nx_d, ny_d;

  always_comb begin
    nx_d = NUM_W'(plx_q) + (NUM_W'(phx_q) << LO_W);
    ny_d = NUM_W'(ply_q) + (NUM_W'(phy_q) << LO_W);
  end

  divw_t data_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      data_q.x.rem    <= nx_d[NUM_W-1:Q_W];
      data_q.x.num_lo <= nx_d[Q_W-1:0];
      data_q.x.quo    <= '0;
      data_q.x.neg    <= neg_x_q5;
      data_q.x.base   <= x1_q5;
      data_q.y.rem    <= ny_d[NUM_W-1:Q_W];
      data_q.y.num_lo <= ny_d[Q_W-1:0];
      data_q.y.quo    <= '0;
      data_q.y.neg    <= neg_y_q5;
      data_q.y.base   <= y1_q5;
      data_q.den      <= den_mag_q5;
      data_q.outcome  <= outcome_q5;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/segi_div_cell.sv =====
// ---------------------------------------------------------------------------
// segi_div_cell
// One restoring division step for both coordinates: shifts in the next
// dividend bit, subtracts the denominator when it fits, emits a quotient bit.
// ---------------------------------------------------------------------------
module segi_div_cell import segi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  divw_t data_i,
  output logic  stall_o,
  output logic  valid_o,
  output divw_t data_o,
  input  logic  stall_i
);

  logic  valid_q;
  logic  adv;
  divw_t data_d, data_q;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  function automatic lane_t step(lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] diff;
    lane_t          o;
    r2   = {l.rem, l.num_lo[Q_W-1]};
    diff = r2 - {1'b0, den};
    o    = l;
    o.num_lo = {l.num_lo[Q_W-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = diff[DEN_W-1:0];
      o.quo = {l.quo[Q_W-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.quo = {l.quo[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    data_d   = data_i;
    data_d.x = step(data_i.x, data_i.den);
    data_d.y = step(data_i.y, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) data_q <= data_d;
  end

endmodule

// ===== rtl/core/segi_back.sv =====
// ---------------------------------------------------------------------------
// segi_back
// For a hit, rounds each quotient to nearest and applies the offset's sign
// to the start coordinate (else zero); holds the result for the receiver.
// ---------------------------------------------------------------------------
module segi_back import segi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  divw_t                     data_i,
  output logic                      stall_o,
  output logic                      out_valid_o,
  output logic [1:0]                outcome_o,
  output logic signed [COORD_W-1:0] hit_x_o,
  output logic signed [COORD_W-1:0] hit_y_o,
  input  logic                      out_stall_i
);

  logic                      valid_q, adv;
  logic [1:0]                outcome_q;
  logic signed [COORD_W-1:0] hx_q, hy_q;

  assign adv     = !valid_q || !out_stall_i;
  assign stall_o = !adv;

  // ties round away from zero: bump when 2*rem >= den
  function automatic logic signed [COORD_W-1:0] finish(lane_t l, logic [DEN_W-1:0] den);
    logic [Q_W:0]     off;
    logic [COORD_W:0] res;
    off = {1'b0, l.quo} + (Q_W+1)'({l.rem, 1'b0} >= {1'b0, den});
    if (l.neg) res = (COORD_W+1)'(l.base) - (COORD_W+1)'(off);
    else       res = (COORD_W+1)'(l.base) + (COORD_W+1)'(off);
    return res[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      outcome_q <= data_i.outcome;
      if (data_i.outcome == OUT_HIT) begin
        hx_q <= finish(data_i.x, data_i.den);
        hy_q <= finish(data_i.y, data_i.den);
      end else begin
        hx_q <= '0;
        hy_q <= '0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign outcome_o   = outcome_q;
  assign hit_x_o     = hx_q;
  assign hit_y_o     = hy_q;

endmodule

// ===== rtl/core/segment_intersection.sv =====
// ---------------------------------------------------------------------------
// segment_intersection
// Two segment intersection test with exact fixed-point arithmetic.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one transaction per
//   segment pair: start and end points of A and B, 29 bit signed with 8
//   fraction bits. The output channel (out_valid_o / out_stall_i) returns
//   one transaction per pair: outcome (0 hit, 1 parallel, 2 outside) and the
//   crossing point, zero unless a hit.
//   The pipeline has six front stages (differences, products, cross
//   terms, classify, split multiply, dividend), a chain of 30 divider cells
//   that each produce one quotient bit for both coordinates, and the output
//   register. A new pair is taken every cycle unless in_stall_o is high.
//   Each stage advances when it is empty or its successor advances, so while
//   the receiver stalls, empty stages upstream still fill; in_stall_o rises
//   only once every stage holds a transaction.
//   Reset empties the pipeline and sets parallel_limit (APB byte address 0)
//   to 1. It must be written only while idle; the block does not enforce this.
// ---------------------------------------------------------------------------
module segment_intersection import segi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] a_start_x_i,
  input  logic signed [COORD_W-1:0] a_start_y_i,
  input  logic signed [COORD_W-1:0] a_end_x_i,
  input  logic signed [COORD_W-1:0] a_end_y_i,
  input  logic signed [COORD_W-1:0] b_start_x_i,
  input  logic signed [COORD_W-1:0] b_start_y_i,
  input  logic signed [COORD_W-1:0] b_end_x_i,
  input  logic signed [COORD_W-1:0] b_end_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                outcome_o,
  output logic signed [COORD_W-1:0] hit_x_o,
  output logic signed [COORD_W-1:0] hit_y_o
);

  logic [LIMIT_W-1:0] limit_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_PARALLEL_LIMIT) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_PARALLEL_LIMIT: prdata = DATA_W'(limit_q);
      default:            prdata = '0;
    endcase
  end

  logic [NUM_CELLS:0] v;
  logic [NUM_CELLS:0] s;
  divw_t              d [NUM_CELLS+1];

  segi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .limit_i     (limit_q),
    .valid_o     (v[0]),
    .data_o      (d[0]),
    .stall_i     (s[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    segi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .data_i  (d[k]),
      .stall_o (s[k]),
      .valid_o (v[k+1]),
      .data_o  (d[k+1]),
      .stall_i (s[k+1])
    );
  end

  segi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v[NUM_CELLS]),
    .data_i      (d[NUM_CELLS]),
    .stall_o     (s[NUM_CELLS]),
    .out_valid_o (out_valid_o),
    .outcome_o   (outcome_o),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for segment_intersection. Pairs of segments are sent
// (a directed set, then constructed crossings, touches, parallel and random
// pairs) under several idle and stall patterns and parallel_limit settings.
// Each result is checked against an exact fixed-point prediction.
// ---------------------------------------------------------------------------
module testbench;
  import segi_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t pair_t [8];  // ax1 ay1 ax2 ay2 bx1 by1 bx2 by2

  typedef struct {
    outcome_e outcome;
    coord_t   hit_x;
    coord_t   hit_y;
  } crossing_t;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     DRAIN_CYCLES   = 45;
  localparam coord_t COORD_MAX      = coord_t'((1 << (COORD_W - 1)) - 1);
  localparam coord_t COORD_MIN      = coord_t'(-(1 << (COORD_W - 1)));

  class segment_scoreboard;
    logic [LIMIT_W-1:0] limit;
    crossing_t          pending[$];
    int                 errors;

    function new();
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    static function longint abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    static function bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
    endfunction

    // point on A at t = tn/den, offset rounded half away from zero
    static function coord_t lerp(longint p1, longint p2, longint tn, longint den);
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] rem;
      longint       diff;
      bit           neg;
      diff = p2 - p1;
      if (tn == 0 || diff == 0) return coord_t'(p1);
      prod = 128'(abs64(tn)) * 128'(abs64(diff));
      quo  = prod / 128'(abs64(den));
      rem  = prod % 128'(abs64(den));
      if (rem >= 128'(abs64(den)) - rem) quo = quo + 1;
      neg = ((tn < 0) != (den < 0)) != (diff < 0);
      return coord_t'(neg ? p1 - longint'(quo) : p1 + longint'(quo));
    endfunction

    function crossing_t predict(pair_t p);
      crossing_t r;
      longint    x1, y1, x2, y2, x3, y3, x4, y4, den, tn, un;
      x1 = longint'(p[0]); y1 = longint'(p[1]);
      x2 = longint'(p[2]); y2 = longint'(p[3]);
      x3 = longint'(p[4]); y3 = longint'(p[5]);
      x4 = longint'(p[6]); y4 = longint'(p[7]);
      r.outcome = OUT_PARALLEL;
      r.hit_x   = '0;
      r.hit_y   = '0;
      den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
      if (den == 0 || abs64(den) < longint'(limit)) return r;
      tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
      un = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
      if (!in_unit(tn, den) || !in_unit(un, den)) begin
        r.outcome = OUT_OUTSIDE;
        return r;
      end
      r.outcome = OUT_HIT;
      r.hit_x   = lerp(x1, x2, tn, den);
      r.hit_y   = lerp(y1, y2, tn, den);
      return r;
    endfunction

    function void note_pair(pair_t p);
      pending.push_back(predict(p));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] outcome, coord_t hx, coord_t hy);
      crossing_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (outcome !== e.outcome)
        report_mismatch($sformatf("outcome %0d, want %0d", outcome, e.outcome));
      if (hx !== e.hit_x)
        report_mismatch($sformatf("hit_x %0d, want %0d", hx, e.hit_x));
      if (hy !== e.hit_y)
        report_mismatch($sformatf("hit_y %0d, want %0d", hy, e.hit_y));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  coord_t             coord [8];
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         outcome_o;
  coord_t             hit_x_o;
  coord_t             hit_y_o;

  segment_scoreboard  sb = new();
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;

  initial for (int i = 0; i < 8; i++) coord[i] = '0;

  always #10 clk_i = ~clk_i;

  segment_intersection dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .a_start_x_i(coord[0]), .a_start_y_i(coord[1]),
    .a_end_x_i(coord[2]), .a_end_y_i(coord[3]),
    .b_start_x_i(coord[4]), .b_start_y_i(coord[5]),
    .b_end_x_i(coord[6]), .b_end_y_i(coord[7]),
    .out_valid_o, .out_stall_i, .outcome_o, .hit_x_o, .hit_y_o
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    pair_t p;
    bit    moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      for (int i = 0; i < 8; i++) p[i] = coord[i];
      sb.note_pair(p);
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(outcome_o, hit_x_o, hit_y_o);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task send_pair(pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 8; i++) coord[i] <= p[i];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task drain;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_PARALLEL_LIMIT;
    pwdata  <= {$urandom} & 32'hFFFF_0000 | DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.limit = value;
  endtask

  function automatic int rnd(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic coord_t clampc(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic pair_t make_pair();
    pair_t  p;
    int     kind, lim;
    longint px, py, dx, dy, m;
    kind = $urandom_range(99);
    lim  = ($urandom_range(3) == 0) ? (1 << 26) : (1 << $urandom_range(4, 20));
    for (int i = 0; i < 4; i++) p[i] = coord_t'(rnd(lim));
    if (kind < 45) begin
      // line B through a point on A
      m  = $urandom_range(256);
      px = longint'(p[0]) + (longint'(p[2]) - p[0]) * m / 256;
      py = longint'(p[1]) + (longint'(p[3]) - p[1]) * m / 256;
      dx = rnd(lim);
      dy = rnd(lim);
      m  = $urandom_range(1, 300);
      p[4] = clampc(px + dx);
      p[5] = clampc(py + dy);
      p[6] = clampc(px - dx * m / 64);
      p[7] = clampc(py - dy * m / 64);
    end else if (kind < 55) begin
      // shared end point
      p[4] = $urandom_range(1) ? p[2] : p[0];
      p[5] = (p[4] == p[2]) ? p[3] : p[1];
      p[6] = coord_t'(rnd(lim));
      p[7] = coord_t'(rnd(lim));
    end else if (kind < 70) begin
      // parallel or nearly so
      dx = rnd(lim);
      dy = rnd(lim);
      p[4] = clampc(longint'(p[0]) + dx);
      p[5] = clampc(longint'(p[1]) + dy);
      p[6] = clampc(longint'(p[2]) + dx + rnd(2));
      p[7] = clampc(longint'(p[3]) + dy + rnd(2));
    end else if (kind < 88) begin
      for (int i = 4; i < 8; i++) p[i] = coord_t'(rnd(lim));
    end else begin
      for (int i = 0; i < 8; i++) p[i] = coord_t'($urandom);
    end
    return p;
  endfunction

  task directed;
    pair_t p;
    p = '{default: 0};
    send_pair(p);                                         // zero denominator
    p = '{0, 0, 256, 256, 0, 256, 256, 0};                // X crossing
    send_pair(p);
    p = '{0, 0, 256, 0, 256, 0, 512, 256};                // touch at end of A
    send_pair(p);
    p = '{0, 0, 256, 0, 0, 0, 0, 256};                    // touch at both starts
    send_pair(p);
    p = '{0, 0, 256, 256, 1024, 0, 768, 256};             // lines cross outside
    send_pair(p);
    p = '{0, 0, 512, 0, 0, 1, 512, 1};                    // parallel, offset
    send_pair(p);
    p = '{0, 0, 3, 1, 0, 1, 1, 0};                        // odd rounding
    send_pair(p);
    p = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
          COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN};
    send_pair(p);
    p = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN};
    send_pair(p);
    p = '{COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 1, COORD_MAX};
    send_pair(p);
    p = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
          COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN};
    send_pair(p);
    p = '{-1, -1, 1, 1, -1, 1, 1, -1};                    // tiny den near limit
    send_pair(p);
    p = '{0, 0, 1, 1, 0, 1, 1, 0};
    send_pair(p);
  endtask

  initial begin
    int                 idle_set  [5] = '{0, 51, 0, 26, 0};
    int                 stall_set [5] = '{0, 0, 51, 26, 0};
    logic [LIMIT_W-1:0] limit_set [5];
    limit_set = '{16'd0, 16'hFFFF, 16'd1, LIMIT_W'($urandom), 16'd2};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    drain();
    write_limit(16'd0);
    directed();
    drain();
    write_limit(16'hFFFF);
    directed();
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_limit(limit_set[ph]);
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < 320; n++) begin
        if (ph == 3 && n == 160) drain();  // sender waits for all results
        send_pair(make_pair());
      end
    end
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
